>>> design/tile_ram_to_tilemap_translator_core_macros.svh
// Assertion macros for the tilemap translator.
// Used by the front and back modules; no other dependencies.
`ifndef TILE_RAM_TO_TILEMAP_TRANSLATOR_CORE_MACROS_SVH
`define TILE_RAM_TO_TILEMAP_TRANSLATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define TMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TMT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMT_ASSERT(label, prop, msg)
`define TMT_ASSERT_RST(label, prop, msg)
`endif

`endif

>>> design/tmt_pkg.sv
// Shared types and constants for the tilemap translator.
// No dependencies; imported by every module of the block.
package tmt_pkg;

  localparam int unsigned TILE_COUNT      = 1024;
  localparam int unsigned RAM_DEPTH       = 4 * TILE_COUNT;
  localparam int unsigned ADDR_W          = $clog2(RAM_DEPTH);
  localparam int unsigned TILE_W          = $clog2(TILE_COUNT);
  localparam int unsigned MAP_COLS        = 32;
  localparam int unsigned JOB_QUEUE_DEPTH = 2;
  localparam int unsigned FG_WORDS        = 8;
  localparam int unsigned BG_WORDS        = 4;

  localparam logic [15:0] FG_BANK_BLANK  = 16'h0800;
  localparam logic [15:0] FG_BANK_NORMAL = 16'h1800;
  localparam logic [15:0] BG_BANK        = 16'h2800;
  localparam logic [3:0]  BG_PLAIN_A     = 4'h1;
  localparam logic [3:0]  BG_PLAIN_B     = 4'hd;
  localparam logic [13:0] ROW_PAIR_OFF   = 14'h0040;
  localparam logic [13:0] FG_HALF_OFF    = 14'h1000;

  localparam logic LAYER_FG = 1'b0;
  localparam logic LAYER_BG = 1'b1;

  localparam logic CFG_FLIP_SCREEN = 1'b0;
  localparam logic CFG_BLANK_MASK  = 1'b1;

  typedef enum logic [1:0] {
    FR_CLEAR,
    FR_IDLE,
    FR_CHECK
  } front_state_t;

  typedef struct packed {
    logic [11:0] window_offset;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic        layer_select;
    logic [13:0] map_word_index;
    logic [15:0] map_word_value;
    logic        final_word;
  } out_item_t;

  typedef struct packed {
    logic        layer;
    logic [12:0] base;
    logic [15:0] color_word;
    logic [15:0] code_word;
  } job_t;

endpackage

>>> design/tmt_fifo.sv
// Short job queue between the front and back parts.
// Depends on tmt_pkg for the job type.
module tmt_fifo #(
  parameter int unsigned DEPTH = tmt_pkg::JOB_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tmt_pkg::job_t push_item,
  output logic          full,
  input  logic          pop,
  output tmt_pkg::job_t head_item,
  output logic          empty
);
  import tmt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/tmt_front.sv
// Front part: tile RAM, reset clearing pass, change detection and job build.
// Depends on tmt_pkg and the assertion macro header.
`include "tile_ram_to_tilemap_translator_core_macros.svh"

module tmt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  tmt_pkg::in_item_t in_item,
  input  logic              flip_screen,
  input  logic [31:0]       blank_color_mask,
  output logic              job_push,
  output tmt_pkg::job_t     job_item,
  input  logic              job_full
);
  import tmt_pkg::*;

  logic [7:0]        ram [RAM_DEPTH];
  front_state_t      state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  in_item_t          item_r;
  logic [7:0]        rd_old_r;
  logic [7:0]        rd_pair_r;
  logic              accept;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic [ADDR_W-1:0] pair_addr;

  logic              is_attr;
  logic              layer;
  logic [7:0]        code_byte;
  logic [7:0]        attr_byte;
  logic [TILE_W-1:0] tile;
  logic [4:0]        col;
  logic [4:0]        row;
  logic [5:0]        mcol;
  logic [5:0]        nrow;
  logic [10:0]       code;
  logic [4:0]        color;
  logic              flip_bit;
  logic [15:0]       code_ext;

  assign accept    = in_push && !in_full;
  assign pair_addr = {in_item.window_offset[ADDR_W-1], ~in_item.window_offset[TILE_W],
                      in_item.window_offset[TILE_W-1:0]};

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    mem_we    = 1'b0;
    mem_wa    = item_r.window_offset;
    mem_wd    = item_r.write_byte;
    job_push  = 1'b0;
    in_full   = 1'b1;
    case (state_r)
      FR_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = FR_IDLE;
        end
      end
      FR_IDLE: begin
        in_full = 1'b0;
        if (in_push) begin
          state_nxt = FR_CHECK;
        end
      end
      FR_CHECK: begin
        if (rd_old_r == item_r.write_byte) begin
          state_nxt = FR_IDLE;
        end else if (!job_full) begin
          mem_we    = 1'b1;
          job_push  = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ram[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_old_r  <= ram[in_item.window_offset];
      rd_pair_r <= ram[pair_addr];
      item_r    <= in_item;
    end
  end

  always_comb begin
    is_attr   = item_r.window_offset[TILE_W];
    layer     = item_r.window_offset[ADDR_W-1];
    code_byte = is_attr ? rd_pair_r : item_r.write_byte;
    attr_byte = is_attr ? item_r.write_byte : rd_pair_r;
    tile      = item_r.window_offset[TILE_W-1:0];
    col       = tile[4:0];
    row       = tile[9:5];
    mcol      = 6'(MAP_COLS) - {1'b0, col};
    nrow      = {1'b0, row} + 6'd1;

    if (layer == LAYER_BG) begin
      code     = {attr_byte[2:0], code_byte};
      color    = {1'b0, attr_byte[7:4]};
      flip_bit = attr_byte[3];
    end else begin
      code     = {1'b0, attr_byte[1:0], code_byte};
      color    = attr_byte[7:3];
      flip_bit = attr_byte[2];
    end
    code_ext = {5'b0, code};

    job_item.layer      = layer;
    job_item.base       = flip_screen ? {mcol, nrow, 1'b0} : {1'b0, row, 1'b0, col, 1'b0};
    job_item.color_word = {flip_screen, flip_screen | flip_bit, 9'b0, color};
    if (layer == LAYER_BG) begin
      if ((color[3:0] == BG_PLAIN_A) || (color[3:0] == BG_PLAIN_B)) begin
        job_item.code_word = code_ext;
      end else begin
        job_item.code_word = code_ext + BG_BANK;
      end
    end else begin
      job_item.code_word = code_ext +
                           (blank_color_mask[color] ? FG_BANK_BLANK : FG_BANK_NORMAL);
    end
  end

  `TMT_ASSERT(a_push_only_with_room, job_push |-> !job_full, "job pushed into full queue")
  `TMT_ASSERT(a_accept_to_check, accept |=> (state_r == FR_CHECK), "accept did not reach check")
  `TMT_ASSERT_RST(a_reset_starts_clear, !rst_n |=> (state_r == FR_CLEAR) && in_full,
                  "reset did not start clearing pass")

endmodule

>>> design/tmt_back.sv
// Back part: expands one job into its map words and holds the output register.
// Depends on tmt_pkg and the assertion macro header.
`include "tile_ram_to_tilemap_translator_core_macros.svh"

module tmt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  tmt_pkg::job_t      job_item,
  output logic               job_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output tmt_pkg::out_item_t out_item
);
  import tmt_pkg::*;

  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  out_item_t   word;
  logic        load;
  logic        last;
  logic [2:0]  last_step;
  logic [13:0] offset;
  logic        code_sel;

  assign load      = job_valid && (!out_valid_r || out_pop);
  assign last_step = (job_item.layer == LAYER_BG) ? 3'(BG_WORDS - 1) : 3'(FG_WORDS - 1);
  assign last      = (step_r == last_step);
  assign job_pop   = load && last;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (job_item.layer == LAYER_BG) begin
      offset   = step_r[0] ? ROW_PAIR_OFF : '0;
      code_sel = step_r[1];
    end else begin
      offset   = (step_r[1] ? FG_HALF_OFF : '0) | (step_r[0] ? ROW_PAIR_OFF : '0);
      code_sel = step_r[2];
    end
    word.layer_select   = job_item.layer;
    word.map_word_index = ({1'b0, job_item.base} + offset) | {13'b0, code_sel};
    word.map_word_value = code_sel ? job_item.code_word : job_item.color_word;
    word.final_word     = last;

    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = last ? '0 : step_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= word;
    end
  end

  `TMT_ASSERT(a_step_needs_job, (step_r != '0) |-> job_valid, "expansion step without a job")
  `TMT_ASSERT(a_bg_step_range, (job_valid && (job_item.layer == LAYER_BG)) |->
              (step_r <= 3'(BG_WORDS - 1)), "background job past its last word")

endmodule

>>> design/tile_ram_to_tilemap_translator_core.sv
// Top level of the tile RAM to tilemap translator.
// Depends on tmt_pkg, tmt_front, tmt_fifo and tmt_back.
//
// Input queue: in_push/in_full carry CPU byte writes (window offset, byte).
// Result queue: out_empty/out_pop give host tilemap words, oldest first;
// final_word marks the last word of one write.
// Configuration: cfg_valid/cfg_ready write flip_screen (index 0) and
// blank_color_mask (index 1); cfg_ready is low in reset and is registered
// high once reset is released.
// After reset the tile RAM is cleared one byte a cycle: in_full stays high
// until the clear ends, while configuration transfers are still taken.
// The front takes a new write only once it is through with the last one
// (tile RAM read, then compare and store) and holds a changed write while
// the job queue is full; a write that leaves the byte unchanged produces
// nothing. The back emits one word a cycle while the receiver takes them:
// 8 for a foreground write, 4 for a background write.
// When the receiver stalls, the output register holds, the job queue fills,
// and in_full rises.
module tile_ram_to_tilemap_translator_core #(
  parameter int unsigned QUEUE_DEPTH = tmt_pkg::JOB_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tmt_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output tmt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import tmt_pkg::*;

  logic        flip_screen_r;
  logic [31:0] blank_mask_r;
  logic        cfg_ready_r;
  logic        job_push;
  job_t        push_item;
  logic        job_full;
  job_t        head_item;
  logic        job_empty;
  logic        job_pop;

  assign cfg_ready = cfg_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_screen_r <= 1'b0;
      blank_mask_r  <= '0;
      cfg_ready_r   <= 1'b0;
    end else begin
      cfg_ready_r <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FLIP_SCREEN: flip_screen_r <= cfg_data[0];
          CFG_BLANK_MASK:  blank_mask_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  tmt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_item          (in_item),
    .flip_screen      (flip_screen_r),
    .blank_color_mask (blank_mask_r),
    .job_push         (job_push),
    .job_item         (push_item),
    .job_full         (job_full)
  );

  tmt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_item (push_item),
    .full      (job_full),
    .pop       (job_pop),
    .head_item (head_item),
    .empty     (job_empty)
  );

  tmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job_item  (head_item),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
